// File: design/icy_metadata_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the metadata deframer
// Implication checks that are compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ICY_METADATA_DEFRAMER_TOP_MACROS_SVH
`define ICY_METADATA_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH
`define IMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imd assertion failed");
`define IMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("imd assertion failed");
`else
`define IMD_ASSERT_IMP(label, ante, cons)
`define IMD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types, constants and the title prefix table of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imd_pkg;

    localparam int LEN_UNIT   = 16;
    localparam int PREFIX_LEN = 13;
    localparam int ITEM_SLOTS = 3;

    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_TEXT  = 2'd1,
        KIND_MARK  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0]                  rep_cnt;
        logic [3:0]                  total;
        logic [ITEM_SLOTS-1:0][7:0]  item_byte;
        kind_t [ITEM_SLOTS-1:0]      item_kind;
    } desc_t;

    typedef struct packed {
        logic pass_through;
        logic in_body;
    } status_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h72;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h65;
            4'd11:   c = 8'h3D;
            4'd12:   c = 8'h27;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/imd_parser.sv
// ----------------------------------------------------------------------------
// imd_parser
// Framing state and the per-item decision of which results to produce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [15:0]         cfg_write_data,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    output imd_pkg::desc_t      desc,
    output logic                desc_nonempty,
    output imd_pkg::status_t    status
);

    typedef enum logic {
        PH_AUDIO,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        TM_MATCH  = 2'd0,
        TM_TITLE  = 2'd1,
        TM_WHOLE  = 2'd2,
        TM_CLOSED = 2'd3
    } mode_t;

    logic [15:0] metaint_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] audio_count_reg, audio_count_next;
    logic [11:0] meta_rem_reg, meta_rem_next;
    logic [3:0]  prefix_pos_reg, prefix_pos_next;
    mode_t       mode_reg, mode_next;
    logic        quote_reg, quote_next;

    logic [11:0] len;
    logic [1:0]  n;
    logic [3:0]  rep;
    logic [imd_pkg::ITEM_SLOTS-1:0][7:0] ibyte;
    imd_pkg::kind_t [imd_pkg::ITEM_SLOTS-1:0] ikind;

    always_comb
    begin
        phase_next       = phase_reg;
        audio_count_next = audio_count_reg;
        meta_rem_next    = meta_rem_reg;
        prefix_pos_next  = prefix_pos_reg;
        mode_next        = mode_reg;
        quote_next       = quote_reg;
        n     = 2'd0;
        rep   = 4'd0;
        ibyte = '0;
        ikind = '{default: imd_pkg::KIND_AUDIO};
        len   = 12'({4'd0, data_byte} * 12'(imd_pkg::LEN_UNIT));

        if (phase_reg == PH_AUDIO)
        begin
            if (metaint_reg == 16'd0 || audio_count_reg < metaint_reg)
            begin
                if (metaint_reg != 16'd0)
                begin
                    audio_count_next = audio_count_reg + 16'd1;
                end
                ibyte[n] = data_byte;
                ikind[n] = imd_pkg::KIND_AUDIO;
                n = n + 2'd1;
            end
            else
            begin
                audio_count_next = 16'd0;
                if (len != 12'd0)
                begin
                    phase_next      = PH_BODY;
                    meta_rem_next   = len;
                    prefix_pos_next = 4'd0;
                    quote_next      = 1'b0;
                    mode_next = (len > 12'(imd_pkg::PREFIX_LEN)) ? TM_MATCH : TM_WHOLE;
                end
            end
        end
        else
        begin
            unique case (mode_reg)
                TM_MATCH:
                begin
                    if (prefix_pos_reg < 4'(imd_pkg::PREFIX_LEN) &&
                        data_byte == imd_pkg::prefix_char(prefix_pos_reg))
                    begin
                        prefix_pos_next = prefix_pos_reg + 4'd1;
                        if (prefix_pos_next >= 4'(imd_pkg::PREFIX_LEN))
                        begin
                            mode_next = TM_TITLE;
                        end
                    end
                    else
                    begin
                        rep = prefix_pos_reg;
                        ibyte[n] = data_byte;
                        ikind[n] = imd_pkg::KIND_TEXT;
                        n = n + 2'd1;
                        mode_next = TM_WHOLE;
                    end
                end
                TM_TITLE:
                begin
                    if (quote_reg && data_byte == imd_pkg::CHAR_SEMI)
                    begin
                        quote_next = 1'b0;
                        mode_next  = TM_CLOSED;
                    end
                    else
                    begin
                        if (quote_reg)
                        begin
                            ibyte[n] = imd_pkg::CHAR_QUOTE;
                            ikind[n] = imd_pkg::KIND_TEXT;
                            n = n + 2'd1;
                        end
                        if (data_byte == imd_pkg::CHAR_QUOTE)
                        begin
                            quote_next = 1'b1;
                        end
                        else
                        begin
                            quote_next = 1'b0;
                            ibyte[n] = data_byte;
                            ikind[n] = imd_pkg::KIND_TEXT;
                            n = n + 2'd1;
                        end
                    end
                end
                TM_WHOLE:
                begin
                    ibyte[n] = data_byte;
                    ikind[n] = imd_pkg::KIND_TEXT;
                    n = n + 2'd1;
                end
                TM_CLOSED:
                begin
                end
            endcase

            meta_rem_next = meta_rem_reg - 12'd1;
            if (meta_rem_next == 12'd0)
            begin
                if (mode_next == TM_TITLE && quote_next)
                begin
                    ibyte[n] = imd_pkg::CHAR_QUOTE;
                    ikind[n] = imd_pkg::KIND_TEXT;
                    n = n + 2'd1;
                end
                quote_next       = 1'b0;
                prefix_pos_next  = 4'd0;
                mode_next        = TM_MATCH;
                phase_next       = PH_AUDIO;
                audio_count_next = 16'd0;
                ibyte[n] = 8'd0;
                ikind[n] = imd_pkg::KIND_MARK;
                n = n + 2'd1;
            end
        end
    end

    assign desc.rep_cnt   = rep;
    assign desc.total     = rep + {2'd0, n};
    assign desc.item_byte = ibyte;
    assign desc.item_kind = ikind;
    assign desc_nonempty  = (desc.total != 4'd0);

    assign status.pass_through = (metaint_reg == 16'd0);
    assign status.in_body      = (phase_reg == PH_BODY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metaint_reg     <= 16'd0;
            phase_reg       <= PH_AUDIO;
            audio_count_reg <= 16'd0;
            meta_rem_reg    <= 12'd0;
            prefix_pos_reg  <= 4'd0;
            mode_reg        <= TM_MATCH;
            quote_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                metaint_reg <= cfg_write_data;
            end
            if (in_fire)
            begin
                phase_reg       <= phase_next;
                audio_count_reg <= audio_count_next;
                meta_rem_reg    <= meta_rem_next;
                prefix_pos_reg  <= prefix_pos_next;
                mode_reg        <= mode_next;
                quote_reg       <= quote_next;
            end
        end
    end

endmodule

// File: design/imd_emitter.sv
// ----------------------------------------------------------------------------
// imd_emitter
// Holds one item's results and sends one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_emitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_load,
    input  imd_pkg::desc_t   desc_in,
    output logic             accept_ok,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       kind
);

    imd_pkg::desc_t desc_reg;
    logic           desc_valid_reg;
    logic [3:0]     pos_reg;
    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    imd_pkg::kind_t out_kind_reg;

    logic           out_load;
    logic           emit;
    logic           last;
    logic [3:0]     idx;
    logic [7:0]     cur_byte;
    imd_pkg::kind_t cur_kind;

    assign out_load  = !out_valid_reg || !out_stall;
    assign emit      = desc_valid_reg && out_load;
    assign last      = (pos_reg == desc_reg.total - 4'd1);
    assign accept_ok = !desc_valid_reg || (emit && last);
    assign idx       = pos_reg - desc_reg.rep_cnt;

    always_comb
    begin
        cur_byte = 8'd0;
        cur_kind = imd_pkg::KIND_TEXT;
        if (pos_reg < desc_reg.rep_cnt)
        begin
            cur_byte = imd_pkg::prefix_char(pos_reg);
        end
        else
        begin
            unique case (idx[1:0])
                2'd0:
                begin
                    cur_byte = desc_reg.item_byte[0];
                    cur_kind = desc_reg.item_kind[0];
                end
                2'd1:
                begin
                    cur_byte = desc_reg.item_byte[1];
                    cur_kind = desc_reg.item_kind[1];
                end
                2'd2:
                begin
                    cur_byte = desc_reg.item_byte[2];
                    cur_kind = desc_reg.item_kind[2];
                end
                default:
                begin
                    cur_byte = 8'd0;
                    cur_kind = imd_pkg::KIND_TEXT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            pos_reg        <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
            if (desc_load)
            begin
                desc_valid_reg <= 1'b1;
                pos_reg        <= 4'd0;
            end
            else if (emit && last)
            begin
                desc_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_load)
        begin
            desc_reg <= desc_in;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_kind_reg <= cur_kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = out_kind_reg;

endmodule

// File: design/icy_metadata_deframer_top.sv
// A result passes from the emitter's descriptor register to its output register.
// Throughput: one item per cycle while items give at most one result and out_stall is low.
// An item with k results holds the input while its results leave, one per unstalled cycle.
// A prefix mismatch replays up to 12 held bytes, so such an item gives up to 13 results.
// Reset is asynchronous and active low; metaint returns to zero, which means pass-through.
// ----------------------------------------------------------------------------
// icy_metadata_deframer_top
// Splits a received byte stream into audio bytes, metadata text and markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "icy_metadata_deframer_top_macros.svh"

module icy_metadata_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  kind
);

    imd_pkg::desc_t   desc;
    imd_pkg::status_t status;
    logic             desc_nonempty;
    logic             accept_ok;
    logic             in_fire;

    assign in_stall = !accept_ok;
    assign in_fire  = in_valid && accept_ok;

    imd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_fire        (in_fire),
        .data_byte      (data_byte),
        .desc           (desc),
        .desc_nonempty  (desc_nonempty),
        .status         (status)
    );

    imd_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_load  (in_fire && desc_nonempty),
        .desc_in    (desc),
        .accept_ok  (accept_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .kind       (kind)
    );

    `IMD_ASSERT_IMP(a_marker_zero, out_valid && kind == imd_pkg::KIND_MARK, out_byte == 8'd0)
    `IMD_ASSERT_NEXT(a_empty_no_stall, in_fire && !desc_nonempty, !in_stall)
    `IMD_ASSERT_NEXT(a_pass_audio, in_fire && status.pass_through && !status.in_body, ##1 out_valid)

endmodule

// File: tb/icy_metadata_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer_top_tb
// Drives byte streams with in-band metadata blocks into the deframer.
// Every accepted item is run through a behavioral model of the block, and
// each result is checked in order against the model's output.
// Directed tests cover:
//   - pass-through and the metaint extremes;
//   - stream title extraction, lone quotes, and unterminated titles;
//   - prefix mismatches and zero-length blocks;
//   - metaint changes in the middle of a block.
// Random frames then run under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icy_metadata_deframer_top_tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 12;
    localparam int MAX_REPORTS  = 10;
    localparam logic [0:12][7:0] TITLE_TAG = "StreamTitle='";

    typedef enum logic {STREAM_AUDIO, STREAM_BODY} stream_phase_t;
    typedef enum logic [1:0] {BODY_MATCH, BODY_TITLE, BODY_WHOLE, BODY_CLOSED} body_mode_t;

    typedef struct packed {
        logic [7:0]     value;
        imd_pkg::kind_t kind;
    } demux_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic [1:0]  kind;

    logic [15:0]   metaint_m;
    stream_phase_t phase_m;
    logic [15:0]   audio_cnt_m;
    logic [11:0]   body_left_m;
    logic [3:0]    tag_pos_m;
    body_mode_t    mode_m;
    logic          quote_held_m;

    demux_item_t demux_queue[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    icy_metadata_deframer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .kind           (kind)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic void push_demux(input logic [7:0] v, input imd_pkg::kind_t k);
        demux_item_t it;
        it.value = v;
        it.kind = k;
        demux_queue.push_back(it);
    endfunction

    function automatic void demux_byte(input logic [7:0] b);
        logic take;
        if (phase_m == STREAM_AUDIO)
        begin
            if (metaint_m == 16'd0 || audio_cnt_m < metaint_m)
            begin
                if (metaint_m != 16'd0)
                    audio_cnt_m = audio_cnt_m + 16'd1;
                push_demux(b, imd_pkg::KIND_AUDIO);
            end
            else
            begin
                // This byte is the length of the metadata block.
                audio_cnt_m = 16'd0;
                body_left_m = 12'(int'(b) * imd_pkg::LEN_UNIT);
                if (body_left_m != 12'd0)
                begin
                    phase_m = STREAM_BODY;
                    tag_pos_m = 4'd0;
                    quote_held_m = 1'b0;
                    mode_m = (body_left_m > imd_pkg::PREFIX_LEN) ? BODY_MATCH : BODY_WHOLE;
                end
            end
            return;
        end
        case (mode_m)
            BODY_MATCH:
            begin
                if (tag_pos_m < imd_pkg::PREFIX_LEN && b == TITLE_TAG[tag_pos_m])
                begin
                    tag_pos_m = tag_pos_m + 4'd1;
                    if (tag_pos_m >= imd_pkg::PREFIX_LEN)
                        mode_m = BODY_TITLE;
                end
                else
                begin
                    for (int i = 0; i < tag_pos_m; i++)
                        push_demux(TITLE_TAG[i], imd_pkg::KIND_TEXT);
                    push_demux(b, imd_pkg::KIND_TEXT);
                    mode_m = BODY_WHOLE;
                end
            end
            BODY_TITLE:
            begin
                take = 1'b1;
                if (quote_held_m)
                begin
                    quote_held_m = 1'b0;
                    if (b == imd_pkg::CHAR_SEMI)
                    begin
                        mode_m = BODY_CLOSED;
                        take = 1'b0;
                    end
                    else
                        push_demux(imd_pkg::CHAR_QUOTE, imd_pkg::KIND_TEXT);
                end
                if (take)
                begin
                    if (b == imd_pkg::CHAR_QUOTE)
                        quote_held_m = 1'b1;
                    else
                        push_demux(b, imd_pkg::KIND_TEXT);
                end
            end
            BODY_WHOLE:
                push_demux(b, imd_pkg::KIND_TEXT);
            default:
                ;
        endcase
        body_left_m = body_left_m - 12'd1;
        if (body_left_m == 12'd0)
        begin
            if (mode_m == BODY_TITLE && quote_held_m)
                push_demux(imd_pkg::CHAR_QUOTE, imd_pkg::KIND_TEXT);
            quote_held_m = 1'b0;
            tag_pos_m = 4'd0;
            mode_m = BODY_MATCH;
            phase_m = STREAM_AUDIO;
            audio_cnt_m = 16'd0;
            push_demux(8'h00, imd_pkg::KIND_MARK);
        end
    endfunction

    function automatic void compare_demux(input logic [7:0] got_byte, input logic [1:0] got_kind);
        demux_item_t want;
        if (demux_queue.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: out_byte=%02h kind=%0d", got_byte, got_kind);
            return;
        end
        want = demux_queue.pop_front();
        if (got_byte !== want.value || got_kind !== want.kind)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch: expected out_byte=%02h kind=%0d, got out_byte=%02h kind=%0d",
                         want.value, want.kind, got_byte, got_kind);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                metaint_m = cfg_write_data;
            if (in_valid && !in_stall)
                demux_byte(data_byte);
            if (out_valid && !out_stall)
                compare_demux(out_byte, kind);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_random_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_title_text(input int unsigned n);
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                send_byte(imd_pkg::CHAR_QUOTE);
            else if (pick < 30)
                send_byte(imd_pkg::CHAR_SEMI);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (demux_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_metaint(input logic [15:0] v);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic test_pass_through();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(imd_pkg::CHAR_QUOTE);
        send_byte(imd_pkg::CHAR_SEMI);
        send_byte(TITLE_TAG[0]);
        drain_results();
    endtask

    task automatic test_title_extraction();
        set_metaint(16'd2);
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("StreamTitle='a';");
        send_random_bytes(2);
        send_byte(8'd2);
        send_text("StreamTitle='it's ok';");
        send_random_bytes(10);
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("StreamTitle='x'y");
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("StreamTitle='a");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("StreamTitle='ab'");
        drain_results();
    endtask

    task automatic test_prefix_mismatch();
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("StreamTitle=Xyz!");
        send_random_bytes(2);
        send_byte(8'd1);
        send_text("Stream title!!!!");
        send_random_bytes(2);
        send_byte(8'd1);
        send_random_bytes(16);
        drain_results();
    endtask

    task automatic test_zero_length();
        send_random_bytes(2);
        send_byte(8'd0);
        send_random_bytes(2);
        send_byte(8'd0);
        send_random_bytes(1);
        drain_results();
    endtask

    task automatic test_metaint_limits();
        set_metaint(16'hFFFF);
        send_random_bytes(4);
        drain_results();
        // The audio count is now above the new metaint, so a length byte comes next.
        set_metaint(16'd1);
        send_byte(8'd1);
        send_text("StreamTitle='z';");
        send_random_bytes(1);
        send_byte(8'd2);
        send_text("StreamTitle='long';");
        send_random_bytes(2 * imd_pkg::LEN_UNIT - 19);
        drain_results();
    endtask

    task automatic test_metaint_write_in_body();
        send_random_bytes(1);
        send_byte(8'd1);
        send_text("StreamTi");
        drain_results();
        set_metaint(16'd3);
        send_text("tle='q';");
        send_random_bytes(3);
        send_byte(8'd0);
        drain_results();
        set_metaint(16'd0);
        send_random_bytes(3);
        drain_results();
    endtask

    task automatic send_random_frame(inout int unsigned sent);
        int unsigned pick;
        int unsigned len_code;
        int unsigned body_len;
        int unsigned text_len;
        int unsigned cut;
        logic [7:0]  c;
        send_random_bytes(metaint_m);
        sent += metaint_m;
        pick = $urandom_range(99);
        len_code = (pick < 10) ? 0 : (pick < 70) ? 1 : (pick < 95) ? 2 : 3;
        send_byte(8'(len_code));
        sent++;
        body_len = len_code * imd_pkg::LEN_UNIT;
        if (body_len == 0)
            return;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            for (int i = 0; i < imd_pkg::PREFIX_LEN; i++)
                send_byte(TITLE_TAG[i]);
            if ($urandom_range(3) != 0)
            begin
                text_len = $urandom_range(body_len - imd_pkg::PREFIX_LEN - 2);
                send_title_text(text_len);
                send_byte(imd_pkg::CHAR_QUOTE);
                send_byte(imd_pkg::CHAR_SEMI);
                sent += imd_pkg::PREFIX_LEN + text_len + 2;
                send_random_bytes(body_len - imd_pkg::PREFIX_LEN - text_len - 2);
            end
            else
            begin
                send_title_text(body_len - imd_pkg::PREFIX_LEN);
                sent += body_len;
            end
        end
        else if (pick < 80)
        begin
            cut = $urandom_range(imd_pkg::PREFIX_LEN - 1);
            for (int unsigned i = 0; i < cut; i++)
                send_byte(TITLE_TAG[i]);
            c = TITLE_TAG[cut] + 8'($urandom_range(1, 255));
            send_byte(c);
            send_random_bytes(body_len - cut - 1);
            sent += body_len;
        end
        else
        begin
            send_random_bytes(body_len);
            sent += body_len;
        end
    endtask

    task automatic test_random_stream(input int unsigned src, input int unsigned sink);
        int unsigned sent;
        sent = 0;
        src_idle_pct = src;
        sink_stall_pct = sink;
        if ($urandom_range(3) == 0)
            set_metaint(16'($urandom_range(11, 40)));
        else
            set_metaint(16'($urandom_range(1, 10)));
        while (sent < RANDOM_ITEMS)
            send_random_frame(sent);
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 16'd0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        out_stall = 1'b0;
        metaint_m = 16'd0;
        phase_m = STREAM_AUDIO;
        audio_cnt_m = 16'd0;
        body_left_m = 12'd0;
        tag_pos_m = 4'd0;
        mode_m = BODY_MATCH;
        quote_held_m = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_title_extraction();
        test_prefix_mismatch();
        test_zero_length();
        test_metaint_limits();
        test_metaint_write_in_body();
        test_random_stream(0, 0);
        test_random_stream(67, 0);
        test_random_stream(0, 67);
        test_random_stream(38, 38);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
